### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, quiet while rst is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

### sv/tscns_pkg.sv
// ----------------------------------------------------------------------------
// tscns_pkg
// shared widths, codes and types of the counter to nanoseconds converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tscns_pkg;

  localparam int CNT_W     = 64;
  localparam int FREQ_W    = 34;
  localparam int MUL_W     = 32;
  localparam int SHIFT_W   = 6;
  localparam int MODE_W    = 2;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 7;
  // quotient bits of the fraction divide, rem * 1e9 / freq < 1e9 < 2**30
  localparam int QUO2_W    = 30;
  localparam int NS_W      = 30;

  localparam logic [NS_W-1:0]   NS_PER_SEC = NS_W'(1000000000);
  localparam logic [STEP_W-1:0] DIV1_STEPS = STEP_W'(CNT_W);
  localparam logic [STEP_W-1:0] DIV2_STEPS = STEP_W'(QUO2_W);

  localparam int MODE_CAL_BIT = 0;
  localparam int MODE_PV_BIT  = 1;

  localparam logic [CMD_W-1:0] CMD_GET_TIME = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CONVERT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ELAPSED  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_HZ        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PV_SYSTEM_TIME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PV_COUNT_STAMP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PV_SHIFT       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PV_MUL         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PV_STABLE      = 3'd7;

  typedef struct packed {
    logic              load;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
  } div_stat_t;

endpackage

### sv/tscns_req_if.sv
// ----------------------------------------------------------------------------
// tscns_req_if
// command channel: one command item with its two counter values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tscns_req_if;
  logic                          valid;
  logic                          ready;
  logic [tscns_pkg::CMD_W-1:0]   command;
  logic [tscns_pkg::CNT_W-1:0]   first_count;
  logic [tscns_pkg::CNT_W-1:0]   second_count;

  modport source (output valid, command, first_count, second_count, input ready);
  modport sink   (input valid, command, first_count, second_count, output ready);
endinterface

### sv/tscns_rsp_if.sv
// ----------------------------------------------------------------------------
// tscns_rsp_if
// result channel: nanoseconds for one command item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tscns_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tscns_pkg::CNT_W-1:0] time_ns;

  modport source (output valid, time_ns, input ready);
  modport sink   (input valid, time_ns, output ready);
endinterface

### sv/tscns_cfg_if.sv
// ----------------------------------------------------------------------------
// tscns_cfg_if
// register write channel: register index and write data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tscns_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tscns_pkg::CFG_IDX_W-1:0] index;
  logic [tscns_pkg::CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/tsc_clock_to_nanoseconds.sv
// ----------------------------------------------------------------------------
// tsc_clock_to_nanoseconds
// time-stamp counter to nanoseconds converter with one shared divider and
// one shared 32 x 32 multiplier under a small sequencer
// steps: paravirtual get time runs shift, two multiplies, sum and latch;
//   calibrated paths run the 64 + 30 bit-serial divide steps of the shared
//   divider with multiplies between; zero results go straight to the output
// commands are taken only while idle, so one item is in flight at a time
// reset: synchronous active high rst clears config registers, sequencer, latch and handshakes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsc_clock_to_nanoseconds (
  input  logic         clk,
  input  logic         rst,
  tscns_req_if.sink    req,
  tscns_rsp_if.source  rsp,
  tscns_cfg_if.sink    cfg
);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PV_SHIFT = 4'd1;
  localparam logic [3:0] S_PV_M0    = 4'd2;
  localparam logic [3:0] S_PV_M1    = 4'd3;
  localparam logic [3:0] S_PV_M2    = 4'd4;
  localparam logic [3:0] S_PV_SUM   = 4'd5;
  localparam logic [3:0] S_PV_LATCH = 4'd6;
  localparam logic [3:0] S_DIV1     = 4'd7;
  localparam logic [3:0] S_SEC0     = 4'd8;
  localparam logic [3:0] S_SEC1     = 4'd9;
  localparam logic [3:0] S_SEC2     = 4'd10;
  localparam logic [3:0] S_REM0     = 4'd11;
  localparam logic [3:0] S_REM1     = 4'd12;
  localparam logic [3:0] S_DIV2     = 4'd13;
  localparam logic [3:0] S_CAL_FIN  = 4'd14;
  localparam logic [3:0] S_ZERO     = 4'd15;

  localparam int CW = tscns_pkg::CNT_W;
  localparam int MW = tscns_pkg::MUL_W;

  // configuration registers
  logic [tscns_pkg::MODE_W-1:0]  clock_mode;
  logic [tscns_pkg::FREQ_W-1:0]  freq_hz;
  logic [CW-1:0]                 base_count;
  logic [CW-1:0]                 pv_system_time;
  logic [CW-1:0]                 pv_count_stamp;
  logic [tscns_pkg::SHIFT_W-1:0] pv_shift;
  logic [MW-1:0]                 pv_mul;
  logic                          pv_stable;

  // sequencer and datapath
  logic [3:0]    state;
  logic [3:0]    state_next;
  logic [CW-1:0] latest_ns;
  logic [CW-1:0] opnd;
  logic [CW-1:0] acc;
  logic          rsp_valid;
  logic [CW-1:0] rsp_data;

  logic          req_accept;
  logic          slot_free;
  logic [CW-1:0] sub_x;
  logic [CW-1:0] sub_y;
  logic [CW:0]   diff;
  logic          borrow;
  logic          is_pv;
  logic          go_pv;
  logic          go_cal;
  logic [tscns_pkg::SHIFT_W-1:0] pv_rsh;
  logic [CW-1:0] shifted;
  logic          pv_newer;
  logic [CW-1:0] rem_sum;

  logic          res_wr;
  logic [CW-1:0] res_val;
  logic          latch_upd;

  // shared units
  tscns_pkg::div_req_t  div_req;
  tscns_pkg::div_stat_t div_stat;
  logic [CW-1:0]                 div_dividend;
  logic [tscns_pkg::FREQ_W-1:0]  div_rem_init;
  logic [CW-1:0]                 div_quo;
  logic [tscns_pkg::FREQ_W-1:0]  div_rem;
  logic [MW-1:0]                 mul_a;
  logic [MW-1:0]                 mul_b;
  logic [2*MW-1:0]               mul_prod;

  tscns_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .dividend  (div_dividend),
    .rem_init  (div_rem_init),
    .divisor   (freq_hz),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  tscns_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  // handshakes: the register port never stalls, commands only when idle
  assign cfg.ready   = 1'b1;
  assign req.ready   = (state == S_IDLE);
  assign req_accept  = req.valid && req.ready;
  assign rsp.valid   = rsp_valid;
  assign rsp.time_ns = rsp_data;
  // output register can take a result this cycle
  assign slot_free   = !rsp_valid || rsp.ready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_mode     <= '0;
      freq_hz        <= '0;
      base_count     <= '0;
      pv_system_time <= '0;
      pv_count_stamp <= '0;
      pv_shift       <= '0;
      pv_mul         <= '0;
      pv_stable      <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        tscns_pkg::CFG_CLOCK_MODE:     clock_mode     <= cfg.data[tscns_pkg::MODE_W-1:0];
        tscns_pkg::CFG_FREQ_HZ:        freq_hz        <= cfg.data[tscns_pkg::FREQ_W-1:0];
        tscns_pkg::CFG_BASE_COUNT:     base_count     <= cfg.data;
        tscns_pkg::CFG_PV_SYSTEM_TIME: pv_system_time <= cfg.data;
        tscns_pkg::CFG_PV_COUNT_STAMP: pv_count_stamp <= cfg.data;
        tscns_pkg::CFG_PV_SHIFT:       pv_shift       <= cfg.data[tscns_pkg::SHIFT_W-1:0];
        tscns_pkg::CFG_PV_MUL:         pv_mul         <= cfg.data[MW-1:0];
        tscns_pkg::CFG_PV_STABLE:      pv_stable      <= cfg.data[0];
      endcase
    end
  end

  // one subtracter at the input picks its operands by command:
  // counter minus stamp, counter minus base, end minus start, or delta itself
  assign is_pv = (req.command == tscns_pkg::CMD_GET_TIME) &&
                 clock_mode[tscns_pkg::MODE_PV_BIT];

  always_comb begin
    sub_x = req.first_count;
    sub_y = '0;
    priority if (is_pv) begin
      sub_y = pv_count_stamp;
    end else if (req.command == tscns_pkg::CMD_GET_TIME) begin
      sub_y = base_count;
    end else if (req.command == tscns_pkg::CMD_ELAPSED) begin
      sub_x = req.second_count;
      sub_y = req.first_count;
    end else begin
      // convert and unknown commands pass the counter through
      sub_y = '0;
    end
  end

  assign diff   = {1'b0, sub_x} - {1'b0, sub_y};
  assign borrow = diff[CW];

  assign go_pv  = is_pv;
  // end equal to start gives zero counts, which divides to zero anyway
  assign go_cal = clock_mode[tscns_pkg::MODE_CAL_BIT] && (freq_hz != '0) &&
                  ((req.command == tscns_pkg::CMD_GET_TIME) ||
                   (req.command == tscns_pkg::CMD_CONVERT) ||
                   ((req.command == tscns_pkg::CMD_ELAPSED) && !borrow));

  // signed shift of the delta: negative codes shift right by 1..32
  assign pv_rsh  = ~pv_shift + 1'b1;
  assign shifted = pv_shift[tscns_pkg::SHIFT_W-1] ? (opnd >> pv_rsh)
                                                  : (opnd << pv_shift[tscns_pkg::SHIFT_W-2:0]);

  // monotonic latch compares as signed
  assign pv_newer = $signed(acc) > $signed(latest_ns);

  // fraction numerator: rem * 1e9, upper partial product lands at bit 32
  assign rem_sum = opnd + {mul_prod[MW-1:0], {MW{1'b0}}};

  // sequencer: operand selection for the shared units and next state
  always_comb begin
    state_next   = state;
    div_req      = '0;
    div_dividend = diff[CW-1:0];
    div_rem_init = '0;
    mul_a        = '0;
    mul_b        = '0;
    res_wr       = 1'b0;
    res_val      = '0;
    latch_upd    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_accept) begin
          if (go_pv) begin
            state_next = S_PV_SHIFT;
          end else if (go_cal) begin
            // seconds divide: counts / freq, 64 quotient bits
            div_req.load  = 1'b1;
            div_req.steps = tscns_pkg::DIV1_STEPS;
            state_next    = S_DIV1;
          end else begin
            state_next = S_ZERO;
          end
        end
      end
      S_PV_SHIFT: state_next = S_PV_M0;
      S_PV_M0: begin
        mul_a      = opnd[MW-1:0];
        mul_b      = pv_mul;
        state_next = S_PV_M1;
      end
      S_PV_M1: begin
        mul_a      = opnd[CW-1:MW];
        mul_b      = pv_mul;
        state_next = S_PV_M2;
      end
      S_PV_M2:  state_next = S_PV_SUM;
      S_PV_SUM: state_next = S_PV_LATCH;
      S_PV_LATCH: begin
        if (slot_free) begin
          res_wr     = 1'b1;
          latch_upd  = !pv_stable && pv_newer;
          res_val    = (pv_stable || pv_newer) ? acc : latest_ns;
          state_next = S_IDLE;
        end
      end
      S_DIV1: begin
        if (!div_stat.busy) begin
          state_next = S_SEC0;
        end
      end
      S_SEC0: begin
        mul_a      = div_quo[MW-1:0];
        mul_b      = MW'(tscns_pkg::NS_PER_SEC);
        state_next = S_SEC1;
      end
      S_SEC1: begin
        mul_a      = div_quo[CW-1:MW];
        mul_b      = MW'(tscns_pkg::NS_PER_SEC);
        state_next = S_SEC2;
      end
      S_SEC2: begin
        mul_a      = div_rem[MW-1:0];
        mul_b      = MW'(tscns_pkg::NS_PER_SEC);
        state_next = S_REM0;
      end
      S_REM0: begin
        mul_a      = MW'(div_rem[tscns_pkg::FREQ_W-1:MW]);
        mul_b      = MW'(tscns_pkg::NS_PER_SEC);
        state_next = S_REM1;
      end
      S_REM1: begin
        // fraction divide: numerator / freq fits in 30 quotient bits, so the
        // top bits start as the partial remainder
        div_req.load  = 1'b1;
        div_req.steps = tscns_pkg::DIV2_STEPS;
        div_dividend  = {rem_sum[tscns_pkg::QUO2_W-1:0], {tscns_pkg::FREQ_W{1'b0}}};
        div_rem_init  = rem_sum[CW-1:tscns_pkg::QUO2_W];
        state_next    = S_DIV2;
      end
      S_DIV2: begin
        if (!div_stat.busy) begin
          state_next = S_CAL_FIN;
        end
      end
      S_CAL_FIN: begin
        if (slot_free) begin
          res_wr     = 1'b1;
          res_val    = acc + CW'(div_quo[tscns_pkg::QUO2_W-1:0]);
          state_next = S_IDLE;
        end
      end
      S_ZERO: begin
        if (slot_free) begin
          res_wr     = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      latest_ns <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (latch_upd) begin
        latest_ns <= acc;
      end
      if (res_wr) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (res_wr) begin
      rsp_data <= res_val;
    end
    unique case (state)
      S_IDLE: begin
        // counter before the stamp clamps the delta to zero
        if (req_accept) begin
          opnd <= (go_pv && borrow) ? '0 : diff[CW-1:0];
        end
      end
      S_PV_SHIFT: opnd <= shifted;
      // low partial product keeps only its integer half
      S_PV_M1:    acc  <= {{MW{1'b0}}, mul_prod[2*MW-1:MW]};
      S_PV_M2:    acc  <= acc + mul_prod;
      S_PV_SUM:   acc  <= acc + pv_system_time;
      S_SEC1:     acc  <= mul_prod;
      S_SEC2:     acc  <= acc + {mul_prod[MW-1:0], {MW{1'b0}}};
      S_REM0:     opnd <= mul_prod;
      default: ;
    endcase
  end

  // ready only with the divider at rest
  `ASSERT_CLK(a_ready_div_idle, req.ready |-> !div_stat.busy, "ready while divider busy")
  // the running maximum moves only when a paravirtual result is written
  `ASSERT_CLK(a_latest_src,
    (!$past(rst) && (latest_ns != $past(latest_ns))) |-> ($past(state) == S_PV_LATCH),
    "latest_ns changed outside latch state")
  // a result shows up only from one of the result states
  `ASSERT_CLK(a_rsp_src,
    (!$past(rst) && $rose(rsp_valid)) |-> ($past(state) == S_PV_LATCH ||
      $past(state) == S_CAL_FIN || $past(state) == S_ZERO),
    "result raised outside result state")

endmodule

### sv/tscns_mul.sv
// ----------------------------------------------------------------------------
// tscns_mul
// shared 32 x 32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tscns_mul (
  input  logic                            clk,
  input  logic [tscns_pkg::MUL_W-1:0]     a,
  input  logic [tscns_pkg::MUL_W-1:0]     b,
  output logic [2*tscns_pkg::MUL_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= {{tscns_pkg::MUL_W{1'b0}}, a} * {{tscns_pkg::MUL_W{1'b0}}, b};
  end

endmodule

### sv/tscns_div.sv
// ----------------------------------------------------------------------------
// tscns_div
// restoring divider, one quotient bit per cycle, by a 34-bit divisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tscns_div (
  input  logic                           clk,
  input  logic                           rst,
  input  tscns_pkg::div_req_t            req,
  input  logic [tscns_pkg::CNT_W-1:0]    dividend,
  input  logic [tscns_pkg::FREQ_W-1:0]   rem_init,
  input  logic [tscns_pkg::FREQ_W-1:0]   divisor,
  output tscns_pkg::div_stat_t           stat,
  output logic [tscns_pkg::CNT_W-1:0]    quotient,
  output logic [tscns_pkg::FREQ_W-1:0]   remainder
);

  logic [tscns_pkg::STEP_W-1:0] steps_left;
  logic [tscns_pkg::CNT_W-1:0]  dv;
  logic [tscns_pkg::FREQ_W-1:0] rem;
  logic [tscns_pkg::FREQ_W:0]   partial;
  logic [tscns_pkg::FREQ_W+1:0] trial;
  logic                         neg;

  assign stat.busy = (steps_left != '0);
  assign quotient  = dv;
  assign remainder = rem;

  // shift in the next dividend bit and try the subtract
  assign partial = {rem, dv[tscns_pkg::CNT_W-1]};
  assign trial   = {1'b0, partial} - {2'b00, divisor};
  assign neg     = trial[tscns_pkg::FREQ_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
    end else if (req.load) begin
      steps_left <= req.steps;
    end else if (stat.busy) begin
      steps_left <= steps_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      dv  <= dividend;
      rem <= rem_init;
    end else if (stat.busy) begin
      dv  <= {dv[tscns_pkg::CNT_W-2:0], ~neg};
      rem <= neg ? partial[tscns_pkg::FREQ_W-1:0] : trial[tscns_pkg::FREQ_W-1:0];
    end
  end

  `ASSERT_NEVER(a_load_busy, req.load && stat.busy, "divider loaded while busy")
  `ASSERT_CLK(a_steps_max, steps_left <= tscns_pkg::DIV1_STEPS, "divider step count too large")

endmodule

### bench/tscns_checker.sv
// ----------------------------------------------------------------------------
// tscns_checker
// watches the command, result and register channels of the counter to
// nanoseconds converter, predicts each result and compares it on arrival
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tscns_checker
  import tscns_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tscns_req_if req,
  tscns_rsp_if rsp,
  tscns_cfg_if cfg,
  output int   pending,
  output int   fail_count
);

  // shadow copy of the register file and of the monotonic latch
  logic [MODE_W-1:0]  mode_r;
  logic [FREQ_W-1:0]  freq_r;
  logic [CNT_W-1:0]   base_r;
  logic [CNT_W-1:0]   sys_r;
  logic [CNT_W-1:0]   stamp_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [MUL_W-1:0]   mul_r;
  logic               stable_r;
  logic [CNT_W-1:0]   latest_r;

  logic [CNT_W-1:0] ns_expected_q[$];

  // counts to ns via the calibrated frequency, 0 when unusable
  function automatic logic [CNT_W-1:0] calibrated_ns(input logic [CNT_W-1:0] counts);
    logic [CNT_W-1:0] f;
    logic [CNT_W-1:0] secs;
    logic [CNT_W-1:0] rem;
    if (!mode_r[MODE_CAL_BIT] || freq_r == '0) return '0;
    f    = CNT_W'(freq_r);
    secs = counts / f;
    rem  = counts % f;
    return secs * CNT_W'(NS_PER_SEC) + (rem * CNT_W'(NS_PER_SEC)) / f;
  endfunction

  // host time plus scaled delta, before the monotonic latch
  function automatic logic [CNT_W-1:0] paravirt_ns(input logic [CNT_W-1:0] now);
    logic [CNT_W-1:0] delta;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    int               amt;
    delta = (now >= stamp_r) ? now - stamp_r : '0;
    if (shift_r[SHIFT_W-1]) begin
      amt   = 64 - int'(shift_r);
      delta = delta >> amt;
    end else begin
      delta = delta << shift_r[SHIFT_W-2:0];
    end
    lo = CNT_W'(delta[31:0]) * CNT_W'(mul_r);
    hi = CNT_W'(delta[63:32]) * CNT_W'(mul_r);
    return sys_r + hi + (lo >> 32);
  endfunction

  // expected time_ns for one command item, updates the latch
  function automatic logic [CNT_W-1:0] predict_time_ns(input logic [CMD_W-1:0] c,
                                                        input logic [CNT_W-1:0] a,
                                                        input logic [CNT_W-1:0] b);
    logic [CNT_W-1:0] ns;
    ns = '0;
    case (c)
      CMD_GET_TIME: begin
        if (mode_r[MODE_PV_BIT]) begin
          ns = paravirt_ns(a);
          if (!stable_r) begin
            if ($signed(ns) > $signed(latest_r)) latest_r = ns;
            else ns = latest_r;
          end
        end else if (mode_r[MODE_CAL_BIT]) begin
          ns = calibrated_ns(a - base_r);
        end
      end
      CMD_CONVERT: ns = calibrated_ns(a);
      CMD_ELAPSED: if (b > a) ns = calibrated_ns(b - a);
      default: ns = '0;
    endcase
    return ns;
  endfunction

  always @(posedge clk) begin
    logic [CNT_W-1:0] want_ns;
    if (rst) begin
      mode_r     = '0;
      freq_r     = '0;
      base_r     = '0;
      sys_r      = '0;
      stamp_r    = '0;
      shift_r    = '0;
      mul_r      = '0;
      stable_r   = 1'b0;
      latest_r   = '0;
      fail_count = 0;
      ns_expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_CLOCK_MODE:     mode_r   = cfg.data[MODE_W-1:0];
          CFG_FREQ_HZ:        freq_r   = cfg.data[FREQ_W-1:0];
          CFG_BASE_COUNT:     base_r   = cfg.data;
          CFG_PV_SYSTEM_TIME: sys_r    = cfg.data;
          CFG_PV_COUNT_STAMP: stamp_r  = cfg.data;
          CFG_PV_SHIFT:       shift_r  = cfg.data[SHIFT_W-1:0];
          CFG_PV_MUL:         mul_r    = cfg.data[MUL_W-1:0];
          CFG_PV_STABLE:      stable_r = cfg.data[0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        ns_expected_q.push_back(predict_time_ns(req.command, req.first_count,
                                                req.second_count));
      if (rsp.valid && rsp.ready) begin
        if (ns_expected_q.size() == 0) begin
          $display("%0t: unexpected result time_ns %h", $time, rsp.time_ns);
          fail_count++;
        end else begin
          want_ns = ns_expected_q.pop_front();
          if (rsp.time_ns !== want_ns) begin
            $display("%0t: time_ns mismatch, expected %h, actual %h",
                     $time, want_ns, rsp.time_ns);
            fail_count++;
          end
        end
      end
    end
    pending <= ns_expected_q.size();
  end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the counter to nanoseconds converter: a directed
// pass over the mode, frequency, shift and latch corner cases, then random
// register settings each followed by a burst of shaped random commands, with
// random gaps on the command side and random stalls on the result side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import tscns_pkg::*;
;

  localparam int ITEMS_TOTAL     = 1150;
  localparam int WATCHDOG_CYCLES = 3000;  // no handshake for this long is a hang
  localparam int END_WAIT        = 150;   // longer than the calibrated latency

  // the package names three commands, the fourth code must return zero
  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;

  logic clk;
  logic rst;

  tscns_req_if req_ch ();
  tscns_rsp_if rsp_ch ();
  tscns_cfg_if cfg_ch ();

  int ns_pending;
  int fail_count;

  tsc_clock_to_nanoseconds dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  tscns_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .pending    (ns_pending),
    .fail_count (fail_count)
  );

  // idling switches, flipped per phase so some phases run flat out
  bit req_gaps;
  bit rsp_stall;
  int items_sent;

  // values last written, used only to shape the commands
  logic [MODE_W-1:0] cur_mode;
  logic [CNT_W-1:0]  cur_base;
  logic [CNT_W-1:0]  cur_stamp;
  logic              cur_stable;
  logic [CNT_W-1:0]  sys_walk;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(16, 60);
  endfunction

  // counter value with random magnitude, extremes now and then
  function automatic logic [CNT_W-1:0] rand_count();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  // delta small enough to keep paravirtual time from jumping to the top
  function automatic logic [CNT_W-1:0] small_count();
    return {$urandom, $urandom} >> $urandom_range(24, 63);
  endfunction

  // random bits above a narrow register, the block keeps only the low ones
  function automatic logic [CNT_W-1:0] with_junk(input logic [CNT_W-1:0] v, input int w);
    return ({$urandom, $urandom} << w) | v;
  endfunction

  // result side: ready toggles on its own schedule
  initial begin
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      int stall;
      stall = rsp_stall ? gap_len() : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // hang detector: any accepted item on any channel restarts the count
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_CYCLES) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // one command item; valid stays high afterwards unless the next gap drops it
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [CNT_W-1:0] a,
                          input logic [CNT_W-1:0] b, input int gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.command      <= c;
    req_ch.first_count  <= a;
    req_ch.second_count <= b;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (ns_pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // full register set, written only while the block is idle
  task automatic setup(input logic [MODE_W-1:0] m, input logic [FREQ_W-1:0] f,
                       input logic [CNT_W-1:0] base, input logic [CNT_W-1:0] sys,
                       input logic [CNT_W-1:0] stamp, input logic [SHIFT_W-1:0] s,
                       input logic [MUL_W-1:0] k, input logic st);
    write_reg(CFG_CLOCK_MODE, with_junk(CNT_W'(m), MODE_W));
    write_reg(CFG_FREQ_HZ, with_junk(CNT_W'(f), FREQ_W));
    write_reg(CFG_BASE_COUNT, base);
    write_reg(CFG_PV_SYSTEM_TIME, sys);
    write_reg(CFG_PV_COUNT_STAMP, stamp);
    write_reg(CFG_PV_SHIFT, with_junk(CNT_W'(s), SHIFT_W));
    write_reg(CFG_PV_MUL, with_junk(CNT_W'(k), MUL_W));
    write_reg(CFG_PV_STABLE, with_junk(CNT_W'(st), 1));
    cfg_ch.valid <= 1'b0;
    cur_mode   = m;
    cur_base   = base;
    cur_stamp  = stamp;
    cur_stable = st;
  endtask

  // random register set biased toward the corners
  task automatic random_setup();
    logic [FREQ_W-1:0]  f;
    logic [SHIFT_W-1:0] s;
    logic [MUL_W-1:0]   k;
    logic               st;
    logic [CNT_W-1:0]   sys;
    case ($urandom_range(0, 7))
      0:       f = '0;
      1:       f = '1;
      2:       f = FREQ_W'(1);
      3:       f = FREQ_W'(1000000000);
      4:       f = FREQ_W'($urandom_range(1, 1000));
      default: f = {2'($urandom_range(0, 3)), 32'($urandom)};
    endcase
    case ($urandom_range(0, 9))
      0:       s = 6'h20;  // shift right by the full 32
      1:       s = 6'h21;
      2:       s = 6'h1f;
      3:       s = '0;
      4:       s = SHIFT_W'($urandom_range(0, 63));
      default: s = SHIFT_W'($urandom_range(0, 16) - 8);
    endcase
    case ($urandom_range(0, 5))
      0:       k = '0;
      1:       k = '1;
      default: k = $urandom;
    endcase
    st = 1'($urandom_range(0, 1));
    // host time creeps upward so the latch keeps moving across phases
    sys_walk = sys_walk + (CNT_W'($urandom_range(0, 4194303)) << 32);
    case ($urandom_range(0, 9))
      0:       sys = st ? 64'h7fff_ffff_ffff_ff00 : sys_walk;
      1:       sys = 64'h8000_0000_0000_0000;
      2:       sys = '1;
      default: sys = sys_walk;
    endcase
    setup(MODE_W'($urandom_range(0, 3)), f, rand_count(), sys, rand_count(), s, k, st);
  endtask

  // one random command shaped around the current registers
  task automatic send_random_item();
    logic [CMD_W-1:0] c;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
    int               r;
    r = $urandom_range(0, 99);
    b = {$urandom, $urandom};
    if (r < 45) begin
      c = CMD_GET_TIME;
      if (cur_mode[MODE_PV_BIT]) begin
        a = cur_stamp + small_count();
        case ($urandom_range(0, 9))
          0: a = cur_stamp - small_count() - 1;  // counter before the stamp
          1: if (cur_stable) a = {$urandom, $urandom};
          default: ;
        endcase
      end else begin
        a = cur_base + rand_count();
      end
    end else if (r < 70) begin
      c = CMD_CONVERT;
      a = rand_count();
    end else if (r < 95) begin
      c = CMD_ELAPSED;
      a = rand_count();
      case ($urandom_range(0, 9))
        0:       b = a;  // end equal to start
        1:       ;       // unrelated end, often before start
        default: b = a + rand_count();
      endcase
    end else begin
      c = CMD_UNDEFINED;
      a = {$urandom, $urandom};
    end
    send_cmd(c, a, b, req_gaps ? gap_len() : 0);
  endtask

  initial begin
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.command      <= CMD_GET_TIME;
    req_ch.first_count  <= '0;
    req_ch.second_count <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_CLOCK_MODE;
    cfg_ch.data         <= '0;
    req_gaps   = 1'b0;
    rsp_stall  = 1'b0;
    items_sent = 0;
    cur_mode   = '0;
    cur_base   = '0;
    cur_stamp  = '0;
    cur_stable = 1'b0;
    sys_walk   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: no clock source, every command gives zero
    send_cmd(CMD_GET_TIME, '1, '0, 0);
    send_cmd(CMD_CONVERT, '1, '0, 0);
    send_cmd(CMD_ELAPSED, '0, '1, 0);
    send_cmd(CMD_UNDEFINED, '1, '1, 0);

    // calibrated at the largest frequency, counter below base wraps
    drain();
    setup(2'b01, '1, 64'h0000_0100_0000_0000, '0, '0, '0, '0, 1'b0);
    send_cmd(CMD_GET_TIME, '0, '0, 0);
    send_cmd(CMD_CONVERT, '0, '0, 0);
    send_cmd(CMD_CONVERT, '1, '0, 0);
    send_cmd(CMD_ELAPSED, 64'd5, 64'd1_000_000_000_005, 0);
    send_cmd(CMD_ELAPSED, 64'd77, 64'd77, 0);
    send_cmd(CMD_ELAPSED, '1, '0, 0);

    // both mode bits: paravirtual wins for get time, shift right by 32,
    // negative host time so the signed latch holds at zero until a wrap
    drain();
    setup(2'b11, FREQ_W'(1000000000), '0, 64'hffff_ffff_ffff_ff00,
          64'h0000_0001_0000_0000, 6'h20, '1, 1'b0);
    send_cmd(CMD_GET_TIME, '0, '0, 0);
    send_cmd(CMD_GET_TIME, '1, '0, 0);
    send_cmd(CMD_GET_TIME, 64'h0000_0001_0000_0000, '0, 0);
    send_cmd(CMD_CONVERT, 64'd2_500_000_000, '0, 0);

    // paravirtual only, stable, largest left shift; calibrated paths off
    drain();
    setup(2'b10, FREQ_W'(1000000000), '0, 64'h7fff_ffff_0000_0000, '0, 6'h1f,
          32'd1, 1'b1);
    send_cmd(CMD_GET_TIME, '1, '0, 0);
    send_cmd(CMD_CONVERT, '1, '0, 0);
    send_cmd(CMD_ELAPSED, '0, '1, 0);

    // calibrated with zero frequency
    drain();
    setup(2'b01, '0, '0, '0, '0, '0, '0, 1'b0);
    send_cmd(CMD_GET_TIME, '1, '0, 0);
    send_cmd(CMD_CONVERT, '1, '0, 0);
    send_cmd(CMD_ELAPSED, '0, '1, 0);

    // random phases, each ends with the block drained before new registers
    while (items_sent < ITEMS_TOTAL) begin
      drain();
      random_setup();
      req_gaps  = ($urandom_range(0, 3) != 0);
      rsp_stall = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(20, 70)) send_random_item();
    end

    drain();
    repeat (END_WAIT) @(posedge clk);
    if (fail_count == 0 && ns_pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### tsc_clock_to_nanoseconds.f
+incdir+sv
sv/tscns_pkg.sv
sv/tscns_req_if.sv
sv/tscns_rsp_if.sv
sv/tscns_cfg_if.sv
sv/tscns_mul.sv
sv/tscns_div.sv
sv/tsc_clock_to_nanoseconds.sv
bench/tscns_checker.sv
bench/tb.sv
